// ===== rtl/segisect_pkg.sv =====
// Shared constants and flag type for the segment intersection pipeline.
package segisect_pkg;

  // Quotient bits per coordinate: 32-bit result plus one bit to detect clipping.
  localparam int unsigned Q_BITS   = 33;
  localparam int unsigned OUT_BITS = 32;

  localparam logic [OUT_BITS-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_BITS-1:0] SAT_NEG = 32'h8000_0000;

  // Per-item control flags that ride along with the divider data.
  typedef struct packed {
    logic mode;      // bounding box test enabled
    logic parallel;  // determinant is zero
    logic neg_x;     // quotient x is negative
    logic neg_y;     // quotient y is negative
    logic ovf_x;     // |x quotient| >= 2^33
    logic ovf_y;     // |y quotient| >= 2^33
  } flags_t;

endpackage

// ===== rtl/segisect_front.sv =====
// Front pipeline: determinant, numerators, magnitudes and divider seed.
module segisect_front #(
  parameter int unsigned C = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [8*C-1:0]                      in_data,
  input  logic                                mode,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2*C+2:0]                      out_den,
  output logic [2*C+2:0]                      out_rem_x,
  output logic [2*C+2:0]                      out_rem_y,
  output logic [segisect_pkg::Q_BITS-1:0]     out_nl_x,
  output logic [segisect_pkg::Q_BITS-1:0]     out_nl_y,
  output segisect_pkg::flags_t                out_flags,
  output logic [8*C-1:0]                      out_crd
);

  localparam int unsigned DIFW = C + 1;
  localparam int unsigned PW   = 2*C + 2;
  localparam int unsigned CW   = 2*C + 1;
  localparam int unsigned DW   = 2*C + 3;
  localparam int unsigned MW   = 3*C + 2;
  localparam int unsigned NW   = 3*C + 3;
  localparam int unsigned Q    = segisect_pkg::Q_BITS;
  localparam int unsigned NS   = 6;

  // Stage valids and ready chain.
  logic [NS-1:0] v;
  logic [NS:0]   rdy;
  logic [8*C-1:0] crd [NS];
  logic [NS-2:0]  md;

  assign rdy[NS] = out_ready;
  for (genvar i = 0; i < NS; i++) begin : g_rdy
    assign rdy[i] = !v[i] || rdy[i+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];

  // Input coordinates, first field lowest.
  logic signed [C-1:0] a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
  assign a1x = in_data[0*C +: C];
  assign a1y = in_data[1*C +: C];
  assign a2x = in_data[2*C +: C];
  assign a2y = in_data[3*C +: C];
  assign b1x = in_data[4*C +: C];
  assign b1y = in_data[5*C +: C];
  assign b2x = in_data[6*C +: C];
  assign b2y = in_data[7*C +: C];

  logic signed [DIFW-1:0] dax_c, day_c, dbx_c, dby_c;
  assign dax_c = DIFW'(a1x) - DIFW'(a2x);
  assign day_c = DIFW'(a1y) - DIFW'(a2y);
  assign dbx_c = DIFW'(b1x) - DIFW'(b2x);
  assign dby_c = DIFW'(b1y) - DIFW'(b2y);

  // Stage registers.
  logic signed [DIFW-1:0] s1_dax, s1_day, s1_dbx, s1_dby;
  logic signed [2*C-1:0]  s1_pa, s1_pb, s1_pc, s1_pd;
  logic signed [PW-1:0]   s1_pe, s1_pf;
  logic signed [DIFW-1:0] s2_dax, s2_day, s2_dbx, s2_dby;
  logic signed [DW-1:0]   s2_den;
  logic signed [CW-1:0]   s2_ca, s2_cb;
  logic signed [MW-1:0]   s3_m1, s3_m2, s3_m3, s3_m4;
  logic [DW-1:0]          s3_dabs, s4_dabs, s5_dabs;
  logic                   s3_dneg, s4_dneg, s3_dz, s4_dz, s5_dz;
  logic signed [NW-1:0]   s4_nx, s4_ny;
  logic [NW-1:0]          s5_ax, s5_ay;
  logic                   s5_negx, s5_negy;

  logic [NW-1:0] rix, riy;
  assign rix = s5_ax >> Q;
  assign riy = s5_ay >> Q;

  // Hold valids; advance where the next stage has room.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
    end
  end

  // Payload: products, differences, divider seed.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      crd[0] <= in_data;
      md[0]  <= mode;
      s1_dax <= dax_c;
      s1_day <= day_c;
      s1_dbx <= dbx_c;
      s1_dby <= dby_c;
      s1_pa  <= (2*C)'(a1x) * (2*C)'(a2y);
      s1_pb  <= (2*C)'(a1y) * (2*C)'(a2x);
      s1_pc  <= (2*C)'(b1x) * (2*C)'(b2y);
      s1_pd  <= (2*C)'(b1y) * (2*C)'(b2x);
      s1_pe  <= PW'(dax_c) * PW'(dby_c);
      s1_pf  <= PW'(day_c) * PW'(dbx_c);
    end
    if (rdy[1]) begin
      crd[1] <= crd[0];
      md[1]  <= md[0];
      s2_dax <= s1_dax;
      s2_day <= s1_day;
      s2_dbx <= s1_dbx;
      s2_dby <= s1_dby;
      s2_den <= DW'(s1_pe) - DW'(s1_pf);
      s2_ca  <= CW'(s1_pa) - CW'(s1_pb);
      s2_cb  <= CW'(s1_pc) - CW'(s1_pd);
    end
    if (rdy[2]) begin
      crd[2]  <= crd[1];
      md[2]   <= md[1];
      s3_m1   <= MW'(s2_ca) * MW'(s2_dbx);
      s3_m2   <= MW'(s2_dax) * MW'(s2_cb);
      s3_m3   <= MW'(s2_ca) * MW'(s2_dby);
      s3_m4   <= MW'(s2_day) * MW'(s2_cb);
      s3_dneg <= s2_den[DW-1];
      s3_dabs <= s2_den[DW-1] ? DW'(-s2_den) : DW'(s2_den);
      s3_dz   <= (s2_den == '0);
    end
    if (rdy[3]) begin
      crd[3]  <= crd[2];
      md[3]   <= md[2];
      s4_nx   <= NW'(s3_m1) - NW'(s3_m2);
      s4_ny   <= NW'(s3_m3) - NW'(s3_m4);
      s4_dabs <= s3_dabs;
      s4_dneg <= s3_dneg;
      s4_dz   <= s3_dz;
    end
    if (rdy[4]) begin
      crd[4]  <= crd[3];
      md[4]   <= md[3];
      s5_ax   <= s4_nx[NW-1] ? NW'(-s4_nx) : NW'(s4_nx);
      s5_ay   <= s4_ny[NW-1] ? NW'(-s4_ny) : NW'(s4_ny);
      s5_negx <= s4_nx[NW-1] ^ s4_dneg;
      s5_negy <= s4_ny[NW-1] ^ s4_dneg;
      s5_dabs <= s4_dabs;
      s5_dz   <= s4_dz;
    end
    if (rdy[5]) begin
      crd[5]             <= crd[4];
      out_den            <= s5_dabs;
      out_rem_x          <= DW'(rix);
      out_rem_y          <= DW'(riy);
      out_nl_x           <= Q'(s5_ax);
      out_nl_y           <= Q'(s5_ay);
      out_flags.mode     <= md[4];
      out_flags.parallel <= s5_dz;
      out_flags.neg_x    <= s5_negx;
      out_flags.neg_y    <= s5_negy;
      out_flags.ovf_x    <= (rix >= NW'(s5_dabs));
      out_flags.ovf_y    <= (riy >= NW'(s5_dabs));
    end
  end

  assign out_crd = crd[NS-1];

endmodule

// ===== rtl/segisect_cell.sv =====
// Divider cell: one restoring quotient bit for x and for y per item.
module segisect_cell #(
  parameter int unsigned DW   = 35,
  parameter int unsigned CRDW = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [DW-1:0]                       in_den,
  input  logic [DW-1:0]                       in_rem_x,
  input  logic [DW-1:0]                       in_rem_y,
  input  logic [segisect_pkg::Q_BITS-1:0]     in_nl_x,
  input  logic [segisect_pkg::Q_BITS-1:0]     in_nl_y,
  input  logic [segisect_pkg::Q_BITS-1:0]     in_q_x,
  input  logic [segisect_pkg::Q_BITS-1:0]     in_q_y,
  input  segisect_pkg::flags_t                in_flags,
  input  logic [CRDW-1:0]                     in_crd,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [DW-1:0]                       out_den,
  output logic [DW-1:0]                       out_rem_x,
  output logic [DW-1:0]                       out_rem_y,
  output logic [segisect_pkg::Q_BITS-1:0]     out_nl_x,
  output logic [segisect_pkg::Q_BITS-1:0]     out_nl_y,
  output logic [segisect_pkg::Q_BITS-1:0]     out_q_x,
  output logic [segisect_pkg::Q_BITS-1:0]     out_q_y,
  output segisect_pkg::flags_t                out_flags,
  output logic [CRDW-1:0]                     out_crd
);

  localparam int unsigned Q = segisect_pkg::Q_BITS;

  logic [DW:0] tx, ty, dext;
  logic        gex, gey;

  // Bring down the next numerator bit and try a subtract.
  assign dext = {1'b0, in_den};
  assign tx   = {in_rem_x, in_nl_x[Q-1]};
  assign ty   = {in_rem_y, in_nl_y[Q-1]};
  assign gex  = (tx >= dext);
  assign gey  = (ty >= dext);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_den   <= in_den;
      out_rem_x <= gex ? DW'(tx - dext) : DW'(tx);
      out_rem_y <= gey ? DW'(ty - dext) : DW'(ty);
      out_nl_x  <= {in_nl_x[Q-2:0], 1'b0};
      out_nl_y  <= {in_nl_y[Q-2:0], 1'b0};
      out_q_x   <= {in_q_x[Q-2:0], gex};
      out_q_y   <= {in_q_y[Q-2:0], gey};
      out_flags <= in_flags;
      out_crd   <= in_crd;
    end
  end

endmodule

// ===== rtl/segisect_back.sv =====
// Back end: sign, saturation, bounding box test and output register.
module segisect_back #(
  parameter int unsigned C = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [segisect_pkg::Q_BITS-1:0]     in_q_x,
  input  logic [segisect_pkg::Q_BITS-1:0]     in_q_y,
  input  segisect_pkg::flags_t                in_flags,
  input  logic [8*C-1:0]                      in_crd,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2*segisect_pkg::OUT_BITS-1:0] out_data,
  output logic [2:0]                          out_user
);

  localparam int unsigned OB = segisect_pkg::OUT_BITS;

  logic s1_v, rdy1, rdy0;
  assign rdy1     = !out_valid || out_ready;
  assign rdy0     = !s1_v || rdy1;
  assign in_ready = rdy0;

  // Saturate each quotient to the signed 32-bit range.
  logic          satx, saty;
  logic [OB-1:0] px_c, py_c;
  always_comb begin
    if (in_flags.neg_x) begin
      satx = in_flags.ovf_x || (in_q_x > {1'b0, segisect_pkg::SAT_NEG});
      px_c = satx ? segisect_pkg::SAT_NEG : OB'(-in_q_x[OB-1:0]);
    end else begin
      satx = in_flags.ovf_x || (in_q_x > {1'b0, segisect_pkg::SAT_POS});
      px_c = satx ? segisect_pkg::SAT_POS : in_q_x[OB-1:0];
    end
    if (in_flags.neg_y) begin
      saty = in_flags.ovf_y || (in_q_y > {1'b0, segisect_pkg::SAT_NEG});
      py_c = saty ? segisect_pkg::SAT_NEG : OB'(-in_q_y[OB-1:0]);
    end else begin
      saty = in_flags.ovf_y || (in_q_y > {1'b0, segisect_pkg::SAT_POS});
      py_c = saty ? segisect_pkg::SAT_POS : in_q_y[OB-1:0];
    end
  end

  // Bounding box edges of both segments.
  logic signed [C-1:0] a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
  assign a1x = in_crd[0*C +: C];
  assign a1y = in_crd[1*C +: C];
  assign a2x = in_crd[2*C +: C];
  assign a2y = in_crd[3*C +: C];
  assign b1x = in_crd[4*C +: C];
  assign b1y = in_crd[5*C +: C];
  assign b2x = in_crd[6*C +: C];
  assign b2y = in_crd[7*C +: C];

  logic signed [OB-1:0] s1_px, s1_py;
  logic signed [OB-1:0] axl, axh, ayl, ayh, bxl, bxh, byl, byh;
  logic                 s1_sat;
  segisect_pkg::flags_t s1_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy0) s1_v <= in_valid;
      if (rdy1) out_valid <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      s1_px    <= px_c;
      s1_py    <= py_c;
      s1_sat   <= satx || saty;
      s1_flags <= in_flags;
      axl <= OB'((a1x < a2x) ? a1x : a2x);
      axh <= OB'((a1x < a2x) ? a2x : a1x);
      ayl <= OB'((a1y < a2y) ? a1y : a2y);
      ayh <= OB'((a1y < a2y) ? a2y : a1y);
      bxl <= OB'((b1x < b2x) ? b1x : b2x);
      bxh <= OB'((b1x < b2x) ? b2x : b1x);
      byl <= OB'((b1y < b2y) ? b1y : b2y);
      byh <= OB'((b1y < b2y) ? b2y : b1y);
    end
  end

  // Containment test, then the output beat.
  logic inbox;
  assign inbox = (s1_px >= axl) && (s1_px <= axh) && (s1_py >= ayl) && (s1_py <= ayh) &&
                 (s1_px >= bxl) && (s1_px <= bxh) && (s1_py >= byl) && (s1_py <= byh);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      if (s1_flags.parallel) begin
        out_data <= '0;
        out_user <= 3'b010;
      end else begin
        out_data <= {s1_py, s1_px};
        out_user <= {s1_sat, 1'b0, (!s1_flags.mode || inbox)};
      end
    end
  end

endmodule

// ===== rtl/segment_intersection_2d.sv =====
// Top level of the pipelined 2-D line and segment intersection block.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | s_tdata: 8 coordinates
//  m_*     | out       | m_tvalid/m_tready  | m_tdata: point; m_tuser: flags
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_data: segment_mode
//
// One pair of segments enters per cycle unless the output stalls; each result passes
// through 6 front stages, one divider cell per quotient bit (33 cells) and 2 back stages.
// Synchronous reset clears all stage valids and sets segment_mode to 1.
// Every stage holds when the one after it is full and stalled; empty stages
// fill in behind a stalled output, so bubbles collapse.
module segment_intersection_2d #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*COORD_BITS-1:0] s_tdata,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // point_x, point_y
  output logic [63:0]             m_tdata,
  // hit, parallel, clipped
  output logic [2:0]              m_tuser,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [0:0]              cfg_data
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned DW   = 2*C + 3;
  localparam int unsigned CRDW = 8*C;
  localparam int unsigned Q    = segisect_pkg::Q_BITS;

  // Mode register.
  logic segment_mode;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_mode <= 1'b1;
    end else if (cfg_valid) begin
      segment_mode <= cfg_data[0];
    end
  end

  // Divider chain links; index 0 is the front output.
  logic                 lv   [Q+1];
  logic                 lr   [Q+1];
  logic [DW-1:0]        lden [Q+1];
  logic [DW-1:0]        lrx  [Q+1];
  logic [DW-1:0]        lry  [Q+1];
  logic [Q-1:0]         lnx  [Q+1];
  logic [Q-1:0]         lny  [Q+1];
  logic [Q-1:0]         lqx  [Q+1];
  logic [Q-1:0]         lqy  [Q+1];
  segisect_pkg::flags_t lfl  [Q+1];
  logic [CRDW-1:0]      lcrd [Q+1];

  assign lqx[0] = '0;
  assign lqy[0] = '0;

  segisect_front #(.C(C)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .mode      (segment_mode),
    .out_valid (lv[0]),
    .out_ready (lr[0]),
    .out_den   (lden[0]),
    .out_rem_x (lrx[0]),
    .out_rem_y (lry[0]),
    .out_nl_x  (lnx[0]),
    .out_nl_y  (lny[0]),
    .out_flags (lfl[0]),
    .out_crd   (lcrd[0])
  );

  for (genvar i = 0; i < Q; i++) begin : g_cell
    segisect_cell #(.DW(DW), .CRDW(CRDW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (lv[i]),
      .in_ready  (lr[i]),
      .in_den    (lden[i]),
      .in_rem_x  (lrx[i]),
      .in_rem_y  (lry[i]),
      .in_nl_x   (lnx[i]),
      .in_nl_y   (lny[i]),
      .in_q_x    (lqx[i]),
      .in_q_y    (lqy[i]),
      .in_flags  (lfl[i]),
      .in_crd    (lcrd[i]),
      .out_valid (lv[i+1]),
      .out_ready (lr[i+1]),
      .out_den   (lden[i+1]),
      .out_rem_x (lrx[i+1]),
      .out_rem_y (lry[i+1]),
      .out_nl_x  (lnx[i+1]),
      .out_nl_y  (lny[i+1]),
      .out_q_x   (lqx[i+1]),
      .out_q_y   (lqy[i+1]),
      .out_flags (lfl[i+1]),
      .out_crd   (lcrd[i+1])
    );
  end

  // Remainders, denominator and leftover numerator bits end at the last cell.
  logic unused_tail;
  assign unused_tail = ^{lden[Q], lrx[Q], lry[Q], lnx[Q], lny[Q]};

  segisect_back #(.C(C)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lv[Q]),
    .in_ready  (lr[Q]),
    .in_q_x    (lqx[Q]),
    .in_q_y    (lqy[Q]),
    .in_flags  (lfl[Q]),
    .in_crd    (lcrd[Q]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule
